>>> sv/ntm_pkg.sv
// Package for the nearest timestamp matcher.
// Holds field widths, operation codes and reset constants; depends on nothing.
package ntm_pkg;

  localparam int STAMP_W     = 63;
  localparam int GAP_W       = 32;
  localparam int OUT_IDX_W   = 10;

  localparam logic [GAP_W-1:0] MAX_GAP_RESET = 32'd10000000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [GAP_W-1:0]   gap_t;

endpackage

>>> sv/nearest_timestamp_matcher_unit.sv
// Nearest timestamp matcher: reference store in a synchronous RAM, walked per query.
// Depends on ntm_pkg.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_opcode, in_stamp
//   out      output     out_valid/out_stall out_matched, out_match_index, out_gap_exceeded
//   cfg      input      cfg_valid/cfg_ready cfg_max_gap
//
// A load beat leaves the unit idle, and the next beat may follow at once.
// A query beat stalls the input while it walks the store from the resume point, with
// one RAM read per cycle from the single read port; the walk is skipped when the
// store is empty or the query lies before the first reference.
// Reset (rst_n low, synchronous) empties the store and clears the resume point;
// the store RAM itself is not cleared, since entries at or beyond the count are never read.
// A result waits in the output register while out_stall is high; the next query
// finishes its walk and then holds until that register is free.
module nearest_timestamp_matcher_unit
  import ntm_pkg::*;
#(
  parameter int REF_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [STAMP_W-1:0]   in_stamp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_matched,
  output logic [OUT_IDX_W-1:0] out_match_index,
  output logic                 out_gap_exceeded,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [GAP_W-1:0]     cfg_max_gap
);

  localparam int IDX_W = (REF_DEPTH > 2) ? $clog2(REF_DEPTH) : 1;
  localparam int CNT_W = $clog2(REF_DEPTH + 1);
  localparam int EXT_W = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Reference store: one write port (loads), one read port (query walk).
  stamp_t mem [REF_DEPTH];
  stamp_t rd_data_r;
  logic   rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic   wr_en;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  stamp_t           first_r, first_nxt;
  logic [IDX_W-1:0] prev_idx_r, prev_idx_nxt;
  logic             prev_vld_r, prev_vld_nxt;
  gap_t             max_gap_r;

  stamp_t           query_r, query_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  stamp_t           last_r, last_nxt;
  logic             have_r, have_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r, out_matched_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             out_gap_r, out_gap_nxt;

  logic             in_acc;
  logic             slot_free;
  logic [IDX_W-1:0] start_idx;
  logic [CNT_W-1:0] j_plus1;
  stamp_t           diff;
  logic             gap_over;
  logic [EXT_W-1:0] hit_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // The resume point is used only while it still names a stored entry.
  assign start_idx = (prev_vld_r && (CNT_W'(prev_idx_r) < count_r)) ? prev_idx_r : '0;
  assign j_plus1   = CNT_W'(j_r) + CNT_W'(1);
  assign diff      = (rd_data_r >= query_r) ? (rd_data_r - query_r) : (query_r - rd_data_r);
  assign gap_over  = (|last_r[STAMP_W-1:GAP_W]) || (last_r[GAP_W-1:0] > max_gap_r);
  assign hit_ext   = EXT_W'(hit_r);

  assign wr_en = in_acc && (in_opcode == OP_LOAD) && (count_r < CNT_W'(REF_DEPTH));

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    first_nxt       = first_r;
    prev_idx_nxt    = prev_idx_r;
    prev_vld_nxt    = prev_vld_r;
    query_nxt       = query_r;
    j_nxt           = j_r;
    last_nxt        = last_r;
    have_nxt        = have_r;
    found_nxt       = found_r;
    hit_nxt         = hit_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_matched_nxt = out_matched_r;
    out_idx_nxt     = out_idx_r;
    out_gap_nxt     = out_gap_r;
    rd_en           = 1'b0;
    rd_addr         = start_idx;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_LOAD) begin
            if (wr_en) begin
              count_nxt = count_r + CNT_W'(1);
              if (count_r == '0) begin
                first_nxt = in_stamp;
              end
            end
          end else begin
            query_nxt = in_stamp;
            found_nxt = 1'b0;
            have_nxt  = 1'b0;
            j_nxt     = start_idx;
            if ((count_r == '0) || (in_stamp < first_r)) begin
              state_nxt = ST_DONE;
            end else begin
              rd_en     = 1'b1;
              state_nxt = ST_CMP;
            end
          end
        end
      end
      ST_CMP: begin
        if (have_r && (diff > last_r)) begin
          found_nxt = 1'b1;
          hit_nxt   = j_r - IDX_W'(1);
          state_nxt = ST_DONE;
        end else begin
          last_nxt = diff;
          have_nxt = 1'b1;
          if (j_plus1 == count_r) begin
            state_nxt = ST_DONE;
          end else begin
            j_nxt   = j_plus1[IDX_W-1:0];
            rd_en   = 1'b1;
            rd_addr = j_plus1[IDX_W-1:0];
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = found_r;
          out_idx_nxt     = found_r ? hit_ext[OUT_IDX_W-1:0] : '0;
          out_gap_nxt     = found_r && gap_over;
          prev_vld_nxt    = found_r;
          prev_idx_nxt    = found_r ? hit_r : '0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_stamp;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      prev_idx_r  <= '0;
      prev_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_gap_r   <= MAX_GAP_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      prev_idx_r  <= prev_idx_nxt;
      prev_vld_r  <= prev_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_gap_r <= cfg_max_gap;
      end
    end
  end

  // Payload registers carry no reset; their use is qualified by control state.
  always_ff @(posedge clk) begin
    first_r       <= first_nxt;
    query_r       <= query_nxt;
    j_r           <= j_nxt;
    last_r        <= last_nxt;
    have_r        <= have_nxt;
    found_r       <= found_nxt;
    hit_r         <= hit_nxt;
    out_matched_r <= out_matched_nxt;
    out_idx_r     <= out_idx_nxt;
    out_gap_r     <= out_gap_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_matched      = out_matched_r;
  assign out_match_index  = out_idx_r;
  assign out_gap_exceeded = out_gap_r;

endmodule

>>> sv/ntm_checker.sv
// Port-level checker for the nearest timestamp matcher, bound to the matcher unit.
// Depends on ntm_pkg.
module ntm_checker
  import ntm_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 in_opcode,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_matched,
  input logic [OUT_IDX_W-1:0] out_match_index,
  input logic                 out_gap_exceeded
);

  // A result that is held back keeps its beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched)
      && $stable(out_match_index) && $stable(out_gap_exceeded))
    else $error("result beat changed while stalled");

  // An unmatched result carries a zero index and no gap flag.
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> (out_match_index == '0) && !out_gap_exceeded)
    else $error("unmatched result with nonzero fields");

  // A query occupies the unit for at least the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_QUERY) |=> in_stall)
    else $error("unit free right after a query");

  // A load never blocks the input.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_LOAD) |=> !in_stall)
    else $error("input stalled after a load");

endmodule

bind nearest_timestamp_matcher_unit ntm_checker u_ntm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_matched      (out_matched),
  .out_match_index  (out_match_index),
  .out_gap_exceeded (out_gap_exceeded)
);

>>> tb/tb.sv
// Self-checking testbench for nearest_timestamp_matcher_unit.
// Predicts every query result from its own copy of the reference store, resume point and gap
// limit, and compares each result beat against it. Depends on ntm_pkg and the unit itself.
module tb;
  import ntm_pkg::*;

  localparam int REF_DEPTH    = 1024;
  // A load never stalls the input, so this drain after the last result leaves the unit idle.
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 10;
  localparam stamp_t STAMP_MAX = '1;

  typedef struct packed {
    logic   opcode;
    stamp_t stamp;
  } stim_beat_t;

  typedef struct packed {
    logic                 matched;
    logic [OUT_IDX_W-1:0] match_index;
    logic                 gap_exceeded;
  } match_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_opcode = OP_LOAD;
  stamp_t               in_stamp = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_matched;
  logic [OUT_IDX_W-1:0] out_match_index;
  logic                 out_gap_exceeded;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  gap_t                 cfg_max_gap = '0;

  nearest_timestamp_matcher_unit #(
    .REF_DEPTH(REF_DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_stamp        (in_stamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_matched     (out_matched),
    .out_match_index (out_match_index),
    .out_gap_exceeded(out_gap_exceeded),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_gap     (cfg_max_gap)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Beats waiting to be offered on the input channel, and the results that the accepted
  // queries are predicted to give, oldest first.
  stim_beat_t stim_beats[$];
  match_t     expected_matches[$];

  // Predicted state of the unit. It is updated only when a beat is really accepted, so it
  // follows the unit exactly however the handshakes fall.
  stamp_t      ref_mem [REF_DEPTH];
  int unsigned ref_count = 0;
  int unsigned resume_at = 0;
  bit          resume_ok = 1'b0;
  gap_t        gap_limit = MAX_GAP_RESET;

  // Run statistics and the failure count.
  int n_loads = 0, n_dropped = 0, n_queries = 0, n_hits = 0, n_over = 0, n_cfg = 0;
  int n_bad = 0;

  // Knobs that the stimulus process sets per phase; the driver and the stall process read them.
  int send_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;

  // Handshake bookkeeping for the driver and the stall process.
  logic in_fire = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  // Bookkeeping for the stimulus generator: the references as they are planned, the top of the
  // ascending sequence, and a cursor that walks forward through the planned references so that
  // queries arrive mostly sorted, the way the resume point expects them.
  stamp_t plan_refs[$];
  stamp_t plan_top = '0;
  int     q_cursor = 0;

  // Appends a reference to the predicted store; a load into a full store is dropped.
  function automatic void store_reference(input stamp_t s);
    if (ref_count < REF_DEPTH) begin
      ref_mem[ref_count] = s;
      ref_count++;
      n_loads++;
    end else begin
      n_dropped++;
    end
  endfunction

  // Walks the predicted store for one query. The walk starts at the previous match if there was
  // one, and stops at the first strictly larger difference; the entry before it is the match.
  // Running off the end, an empty store or a query below the first entry means no match, and
  // then the next walk starts over at entry 0.
  function automatic match_t predict_match(input stamp_t q);
    match_t      r;
    int unsigned j;
    int unsigned hit;
    stamp_t      d;
    stamp_t      last_d;
    bit          have_last;
    bit          found;
    r = '0;
    hit = 0;
    last_d = '0;
    have_last = 1'b0;
    found = 1'b0;
    j = (resume_ok && resume_at < ref_count) ? resume_at : 0;
    if (ref_count > 0 && q >= ref_mem[0]) begin
      while (j < ref_count && !found) begin
        d = (ref_mem[j] >= q) ? ref_mem[j] - q : q - ref_mem[j];
        if (have_last && d > last_d) begin
          found = 1'b1;
          hit = j - 1;
        end else begin
          last_d = d;
          have_last = 1'b1;
          j++;
        end
      end
    end
    n_queries++;
    if (found) begin
      resume_ok = 1'b1;
      resume_at = hit;
      r.matched = 1'b1;
      r.match_index = hit[OUT_IDX_W-1:0];
      r.gap_exceeded = (last_d > stamp_t'(gap_limit));
      n_hits++;
      if (r.gap_exceeded) n_over++;
    end else begin
      resume_ok = 1'b0;
      resume_at = 0;
    end
    return r;
  endfunction

  // Input driver. A new beat is put on the pins at the falling edge once the previous one has
  // been taken; a taken beat may be followed by a short burst of idle cycles. During the long
  // receiver hold-off the sender never idles, so the unit fills up and must stall its input.
  always @(negedge clk) begin : drive_in
    stim_beat_t beat;
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (stim_beats.size() != 0) begin
          beat = stim_beats.pop_front();
          in_valid <= 1'b1;
          in_opcode <= beat.opcode;
          in_stamp <= beat.stamp;
          if (hold_left == 0 && $urandom_range(0, 99) < send_pct) begin
            send_gap <= $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. Random bursts, each counted down in stall_left, plus one long hold-off that is
  // counted here once the stimulus asks for it.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor. At each rising edge it takes the result beat first and the input beat second, so a
  // query accepted at this edge can never be matched against a result leaving at the same edge.
  always @(posedge clk) begin : watch
    match_t want;
    match_t got;
    match_t pred;
    in_fire <= in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_matched, out_match_index, out_gap_exceeded};
        if (expected_matches.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS) begin
            $display("Unexpected result beat: matched=%0b index=%0d gap_exceeded=%0b",
                     got.matched, got.match_index, got.gap_exceeded);
          end
        end else begin
          want = expected_matches.pop_front();
          if (got.matched !== want.matched || got.match_index !== want.match_index ||
              got.gap_exceeded !== want.gap_exceeded) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS) begin
              $display("Result mismatch: expected matched=%0b index=%0d gap_exceeded=%0b,",
                       want.matched, want.match_index, want.gap_exceeded);
              $display("  got matched=%0b index=%0d gap_exceeded=%0b",
                       got.matched, got.match_index, got.gap_exceeded);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_LOAD) begin
          store_reference(in_stamp);
        end else begin
          pred = predict_match(in_stamp);
          expected_matches.insert(expected_matches.size(), pred);
        end
      end
    end
  end

  function automatic stamp_t rand_stamp();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[STAMP_W-1:0];
  endfunction

  // Uniform pick in [lo, hi], in either order; the span is taken in 64 bits so that the full
  // 63-bit range does not wrap to zero.
  function automatic stamp_t pick_between(input stamp_t a, input stamp_t b);
    stamp_t      lo;
    logic [63:0] span;
    logic [63:0] w;
    lo = (a <= b) ? a : b;
    span = ((a <= b) ? {1'b0, b} - {1'b0, a} : {1'b0, a} - {1'b0, b}) + 64'd1;
    w = {$urandom(), $urandom()};
    return lo + stamp_t'(w % span);
  endfunction

  // Next reference of the ascending sequence. Steps of zero give equal neighbors, small and
  // medium steps keep the gap flag mixed around the usual limits, and rare wide steps give
  // gaps beyond a 32-bit limit.
  function automatic stamp_t next_ascending();
    stamp_t step;
    case ($urandom_range(0, 9))
      0:       step = '0;
      7, 8:    step = stamp_t'($urandom_range(1, 1000));
      9:       step = stamp_t'({$urandom_range(0, 255), $urandom()});
      default: step = stamp_t'($urandom_range(1, 20000000));
    endcase
    plan_top = plan_top + step;
    return plan_top;
  endfunction

  function automatic void push_load(input stamp_t s);
    stim_beat_t b;
    b = '{OP_LOAD, s};
    stim_beats.insert(stim_beats.size(), b);
    if (plan_refs.size() < REF_DEPTH) plan_refs.insert(plan_refs.size(), s);
  endfunction

  function automatic void push_query(input stamp_t s);
    stim_beat_t b;
    b = '{OP_QUERY, s};
    stim_beats.insert(stim_beats.size(), b);
  endfunction

  // A well-formed query: a stamp between two neighboring references near the cursor, which
  // mostly moves forward and now and then jumps to a random entry.
  function automatic void push_near_query();
    int n;
    int c;
    n = plan_refs.size();
    if (n == 0) begin
      push_query(rand_stamp());
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        q_cursor = $urandom_range(0, n - 1);
      end else begin
        q_cursor = q_cursor + $urandom_range(0, 2);
        if (q_cursor > n - 1) q_cursor = n - 1;
      end
      c = q_cursor;
      if (c + 1 < n) push_query(pick_between(plan_refs[c], plan_refs[c + 1]));
      else push_query(pick_between(plan_refs[c], plan_refs[c] + 1000));
    end
  endfunction

  // Random phase: mostly ascending loads and sorted queries, with some noise in the form of
  // full-range queries, queries below the first reference and exact hits on random entries.
  function automatic void push_random(input int n);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        push_load(next_ascending());
      end else if (roll < 80) begin
        push_near_query();
      end else if (roll < 90) begin
        push_query(rand_stamp());
      end else if (roll < 95 && plan_refs.size() != 0 && plan_refs[0] != 0) begin
        push_query(pick_between('0, plan_refs[0] - 1));
      end else if (plan_refs.size() != 0) begin
        push_query(plan_refs[$urandom_range(0, plan_refs.size() - 1)]);
      end else begin
        push_query('0);
      end
    end
  endfunction

  // Waits until every queued beat is taken and every predicted result has come back, then
  // lets a load that may still be in flight finish.
  task automatic wait_idle();
    while (stim_beats.size() != 0 || in_valid || expected_matches.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the gap limit through the configuration channel; called only while the unit is idle.
  task automatic write_max_gap(input gap_t v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_max_gap <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gap_limit = v;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset gap limit. It starts with queries into the empty store,
    // then builds a short store with two equal neighbors and exercises a query below the first
    // entry, an exact hit, a tie that must not stop the walk, a gap over the limit, a walk that
    // runs off the end, and the restart from entry 0 after a miss.
    send_pct = 20;
    stall_pct = 20;
    push_query('0);
    push_query(STAMP_MAX);
    push_load(63'd1000);
    push_load(63'd5001000);
    push_load(63'd5001000);
    push_load(63'd40001000);
    push_load(63'd40001500);
    push_query(63'd999);
    push_query(63'd1000);
    push_query(63'd3000000);
    push_query(63'd22000000);
    push_query(63'd40001400);
    push_query('0);
    push_query(63'd5001000);
    push_load(63'd60000000);
    push_query(63'd50000000);
    push_query(63'd40001499);
    push_query(STAMP_MAX);
    plan_top = 63'd60000000;
    q_cursor = 0;
    wait_idle();

    // Zero limit: every nonzero gap is flagged.
    write_max_gap('0);
    send_pct = 15;
    stall_pct = 25;
    push_random(130);
    wait_idle();

    // Largest limit: only the rare wide gaps are flagged.
    write_max_gap('1);
    send_pct = 30;
    stall_pct = 10;
    push_random(130);
    wait_idle();

    // Mid-range limit, with one long receiver hold-off while the sender keeps offering beats.
    write_max_gap(gap_t'($urandom_range(5000000, 20000000)));
    send_pct = 10;
    stall_pct = 30;
    push_random(130);
    hold_request = 1'b1;
    wait_idle();

    // Final part with no idling on either side and a random limit. A few more references are
    // added, one of them out of order, with the largest stamp last; the queries then walk
    // the tail of the store and off its end.
    write_max_gap(gap_t'($urandom()));
    send_pct = 0;
    stall_pct = 0;
    repeat (8) push_load(next_ascending());
    push_load(plan_top - 5);
    push_load(next_ascending());
    push_load(STAMP_MAX);
    push_query(STAMP_MAX);
    push_query('0);
    push_query(plan_refs[plan_refs.size() - 3]);
    push_query(plan_refs[plan_refs.size() - 4]);
    push_query(pick_between(plan_refs[plan_refs.size() - 2], STAMP_MAX));
    q_cursor = plan_refs.size() - 12;
    repeat (20) push_near_query();
    repeat (5) push_query(rand_stamp());
    wait_idle();

    n_bad += expected_matches.size();
    $display("Run covered %0d stored references (%0d loads dropped at a full store)",
             n_loads, n_dropped);
    $display("and %0d queries, %0d matched and %0d over the gap limit, over %0d limit settings.",
             n_queries, n_hits, n_over, n_cfg);
    if (n_bad == 0) begin
      $display("PASS nearest_timestamp_matcher_unit");
    end else begin
      $display("%0d result errors", n_bad);
      $display("FAIL nearest_timestamp_matcher_unit");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, where every query walks the full store.
  initial begin
    #20000000;
    $display("Timed out with %0d beats queued and %0d results outstanding",
             stim_beats.size(), expected_matches.size());
    $display("FAIL nearest_timestamp_matcher_unit");
    $finish;
  end

endmodule
